// ----- design/bba_pkg.sv -----
// Package for the buddy block allocator: sizes, table entry type and codes.
package bba_pkg;

  localparam int UNIT_BYTES = 64;
  localparam int POOL_UNITS = 1024;
  localparam int MAX_ORDERS = 11;

  localparam int UNIT_LOG = $clog2(UNIT_BYTES);
  localparam int IDX_W    = $clog2(POOL_UNITS);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ORD_W    = $clog2(MAX_ORDERS);

  localparam int ADDR_W = 32;
  localparam int SIZE_W = 17;
  localparam int HDR_W  = 6;
  localparam int LIVE_W = 11;
  localparam int STAT_W = 2;
  localparam int CIDX_W = 2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOMEM    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_POOL_BASE    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_POOL_BYTES   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HEADER_BYTES = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic             is_start;
    logic             is_free;
    logic [ORD_W-1:0] order;
  } entry_t;

endpackage

// ----- design/buddy_block_allocator.sv -----
// Buddy block allocator: block table memory, carving sweep and request sequencer.
//
// One request is accepted at a time; its single result goes to an output
// register, so the next request can enter while that result waits. The block
// table is a 1024-entry synchronous memory, read one entry per cycle. An
// allocate walks the chain of block starts from address zero, one block per
// cycle, stopping early on a free block of exactly the needed order, then
// writes one entry per split level. A free checks the freed entry, then reads
// each buddy and merges while it is free and of the same order, then marks the
// merged block free; a rejected free ends without a write. After reset and
// after every write of pool_bytes a carving pass rewrites the whole table
// while no request is accepted; configuration writes are always taken.
module buddy_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [bba_pkg::SIZE_W-1:0]    in_req_size,
  input  logic [bba_pkg::ADDR_W-1:0]    in_free_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::STAT_W-1:0]    out_status,
  output logic [bba_pkg::ADDR_W-1:0]    out_address,
  output logic [bba_pkg::LIVE_W-1:0]    out_pending,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bba_pkg::ADDR_W-1:0]    cfg_data
);
  import bba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CARVE     = 9'b000000010,
    S_SCAN      = 9'b000000100,
    S_SPLIT     = 9'b000001000,
    S_FREE_CHK  = 9'b000010000,
    S_MERGE_RD  = 9'b000100000,
    S_MERGE_CHK = 9'b001000000,
    S_FIN       = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   base_r;
  logic [HDR_W-1:0]    hdr_r;
  logic [CNT_W-1:0]    units_r;
  logic [LIVE_W-1:0]   live_r, live_nxt;
  logic [IDX_W-1:0]    cl_addr_r, cl_addr_nxt;
  logic [CNT_W-1:0]    cl_next_r, cl_next_nxt;
  logic [CNT_W-1:0]    cur_r, cur_nxt;
  logic [IDX_W-1:0]    u_r, u_nxt;
  logic [IDX_W-1:0]    b_r, b_nxt;
  logic [ORD_W-1:0]    ord_r, ord_nxt;
  logic [ORD_W-1:0]    k_r, k_nxt;
  logic [ORD_W-1:0]    best_ord_r, best_ord_nxt;
  logic                found_r, found_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [ADDR_W-1:0]   out_address_r;
  logic [LIVE_W-1:0]   out_pending_r;

  entry_t              mem [POOL_UNITS];
  entry_t              rdata_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  entry_t              wr_data;

  logic                   in_acc;
  logic                   carve_restart;
  logic [CNT_W-1:0]       units_cfg;
  logic [SIZE_W:0]        need;
  logic [ORD_W-1:0]       k_calc;
  logic                   k_fit;
  logic [ADDR_W-1:0]      rel;
  logic [ADDR_W-1:0]      rel_unit;
  logic                   free_ok;
  logic [CNT_W-1:0]       cl_rem;
  logic [ORD_W-1:0]       cl_ord;
  logic [CNT_W-1:0]       scan_nxt;
  logic                   cand;
  logic [IDX_W-1:0]       bud;
  logic [ORD_W-1:0]       ord_m1;
  logic                   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign carve_restart = cfg_valid && (cfg_index == CFG_POOL_BYTES);

  always_comb begin
    logic [ADDR_W-1:0] u_all;
    u_all = {15'b0, cfg_data[SIZE_W-1:0]} >> UNIT_LOG;
    if (u_all > ADDR_W'(POOL_UNITS)) units_cfg = CNT_W'(POOL_UNITS);
    else                             units_cfg = u_all[CNT_W-1:0];
  end

  // smallest order whose block covers payload plus header
  always_comb begin
    need   = {1'b0, in_req_size} + (SIZE_W+1)'(hdr_r);
    k_calc = '0;
    k_fit  = 1'b0;
    for (int i = MAX_ORDERS - 1; i >= 0; i--) begin
      if ((ADDR_W'(UNIT_BYTES) << i) >= ADDR_W'(need)) begin
        k_calc = ORD_W'(i);
        k_fit  = 1'b1;
      end
    end
  end

  assign rel      = in_free_address - base_r - ADDR_W'(hdr_r);
  assign rel_unit = rel >> UNIT_LOG;
  assign free_ok  = (rel[UNIT_LOG-1:0] == '0) && (rel_unit < ADDR_W'(units_r));

  // carve order: largest power of two within the remaining units, capped
  always_comb begin
    cl_rem = units_r - {1'b0, cl_addr_r};
    cl_ord = '0;
    for (int i = 0; i < MAX_ORDERS; i++) begin
      if (cl_rem[i]) cl_ord = ORD_W'(i);
    end
  end

  assign scan_nxt = cur_r + (CNT_W'(1) << rdata_r.order);
  assign cand     = rdata_r.is_start && rdata_r.is_free && (rdata_r.order >= k_r) &&
                    (!found_r || (rdata_r.order < best_ord_r));
  assign bud      = u_r ^ (IDX_W'(1) << ord_r);
  assign ord_m1   = ord_r - ORD_W'(1);

  always_comb begin
    state_nxt      = state_r;
    live_nxt       = live_r;
    cl_addr_nxt    = cl_addr_r;
    cl_next_nxt    = cl_next_r;
    cur_nxt        = cur_r;
    u_nxt          = u_r;
    b_nxt          = b_r;
    ord_nxt        = ord_r;
    k_nxt          = k_r;
    best_ord_nxt   = best_ord_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_addr_nxt = '0;
          if (in_req_type == REQ_ALLOC) begin
            k_nxt     = k_calc;
            cur_nxt   = '0;
            found_nxt = 1'b0;
            if (!k_fit || (units_r == '0)) begin
              res_status_nxt = ST_NOMEM;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SCAN;
            end
          end else begin
            rd_addr = rel[UNIT_LOG +: IDX_W];
            u_nxt   = rel[UNIT_LOG +: IDX_W];
            if (free_ok) begin
              state_nxt = S_FREE_CHK;
            end else begin
              res_status_nxt = ST_BAD_FREE;
              state_nxt      = S_DONE;
            end
          end
        end
      end
      S_CARVE: begin
        wr_en   = 1'b1;
        wr_addr = cl_addr_r;
        if (({1'b0, cl_addr_r} == cl_next_r) && ({1'b0, cl_addr_r} < units_r)) begin
          wr_data     = '{is_start: 1'b1, is_free: 1'b1, order: cl_ord};
          cl_next_nxt = cl_next_r + (CNT_W'(1) << cl_ord);
        end
        cl_addr_nxt = cl_addr_r + IDX_W'(1);
        if (cl_addr_r == IDX_W'(POOL_UNITS - 1)) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (cand && (rdata_r.order == k_r)) begin
          u_nxt     = cur_r[IDX_W-1:0];
          ord_nxt   = rdata_r.order;
          state_nxt = S_SPLIT;
        end else if (scan_nxt >= units_r) begin
          if (cand) begin
            u_nxt     = cur_r[IDX_W-1:0];
            ord_nxt   = rdata_r.order;
            state_nxt = S_SPLIT;
          end else if (found_r) begin
            ord_nxt   = best_ord_r;
            state_nxt = S_SPLIT;
          end else begin
            res_status_nxt = ST_NOMEM;
            state_nxt      = S_DONE;
          end
        end else begin
          if (cand) begin
            u_nxt        = cur_r[IDX_W-1:0];
            best_ord_nxt = rdata_r.order;
            found_nxt    = 1'b1;
          end
          cur_nxt = scan_nxt;
          rd_addr = scan_nxt[IDX_W-1:0];
        end
      end
      S_SPLIT: begin
        wr_en = 1'b1;
        if (ord_r > k_r) begin
          // free the upper half of this level
          wr_addr = u_r + (IDX_W'(1) << ord_m1);
          wr_data = '{is_start: 1'b1, is_free: 1'b1, order: ord_m1};
          ord_nxt = ord_m1;
        end else begin
          wr_addr        = u_r;
          wr_data        = '{is_start: 1'b1, is_free: 1'b0, order: k_r};
          live_nxt       = live_r + LIVE_W'(1);
          res_status_nxt = ST_OK;
          res_addr_nxt   = base_r + (ADDR_W'(u_r) << UNIT_LOG) + ADDR_W'(hdr_r);
          state_nxt      = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (rdata_r.is_start && !rdata_r.is_free) begin
          ord_nxt   = rdata_r.order;
          state_nxt = S_MERGE_RD;
        end else begin
          res_status_nxt = ST_BAD_FREE;
          state_nxt      = S_DONE;
        end
      end
      S_MERGE_RD: begin
        if ((ord_r < ORD_W'(MAX_ORDERS - 1)) && ({1'b0, bud} < units_r)) begin
          rd_addr   = bud;
          b_nxt     = bud;
          state_nxt = S_MERGE_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MERGE_CHK: begin
        if (rdata_r.is_start && rdata_r.is_free && (rdata_r.order == ord_r)) begin
          // clear the upper start, continue from the lower one
          wr_en     = 1'b1;
          wr_addr   = (u_r < b_r) ? b_r : u_r;
          u_nxt     = (u_r < b_r) ? u_r : b_r;
          ord_nxt   = ord_r + ORD_W'(1);
          state_nxt = S_MERGE_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        wr_en   = 1'b1;
        wr_addr = u_r;
        wr_data = '{is_start: 1'b1, is_free: 1'b1, order: ord_r};
        if (live_r != '0) live_nxt = live_r - LIVE_W'(1);
        res_status_nxt = ST_OK;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (carve_restart) begin
      state_nxt   = S_CARVE;
      cl_addr_nxt = '0;
      cl_next_nxt = '0;
      live_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CARVE;
      base_r      <= '0;
      hdr_r       <= HDR_W'(16);
      units_r     <= CNT_W'(POOL_UNITS);
      live_r      <= '0;
      cl_addr_r   <= '0;
      cl_next_r   <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      cl_addr_r <= cl_addr_nxt;
      cl_next_r <= cl_next_nxt;
      found_r   <= found_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_POOL_BASE:    base_r  <= cfg_data;
          CFG_POOL_BYTES:   units_r <= units_cfg;
          CFG_HEADER_BYTES: hdr_r   <= cfg_data[HDR_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_ready)                out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    u_r          <= u_nxt;
    b_r          <= b_nxt;
    ord_r        <= ord_nxt;
    k_r          <= k_nxt;
    best_ord_r   <= best_ord_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r  <= res_status_r;
      out_address_r <= res_addr_r;
      out_pending_r <= live_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_address = out_address_r;
  assign out_pending = out_pending_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LIVE_W'(POOL_UNITS))
    else $error("live count beyond pool units");
  a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> (ord_r >= k_r))
    else $error("split below requested order");
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_address_r == '0))
    else $error("failed request carries an address");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc) |=> (state_r != S_IDLE) || carve_restart || $past(carve_restart))
    else $error("accepted request left no work");

endmodule
